// ===== sv/u8wc_pkg.sv =====
`default_nettype none

package u8wc_pkg;

  // Counter widths for line and column tracking.
  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned COLUMN_BITS = 16;

  // Widths of the result fields.
  localparam int unsigned CP_BITS     = 21;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned M_DATA_BITS = 56;

  localparam logic [LINE_BITS-1:0]   LINE_SAT   = '1;
  localparam logic [COLUMN_BITS-1:0] COLUMN_SAT = '1;

  localparam logic [CP_BITS-1:0] CP_NEWLINE   = 21'h00000A;
  localparam logic [CP_BITS-1:0] CP_MIN_2B    = 21'h000080;
  localparam logic [CP_BITS-1:0] CP_MIN_3B    = 21'h000800;
  localparam logic [CP_BITS-1:0] CP_MIN_4B    = 21'h010000;
  localparam logic [CP_BITS-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_BITS-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CP_BITS-1:0] CP_SURR_HI   = 21'h00DFFF;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_APOS   = 8'h27;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_WORD  = 2'd0,
    KIND_DELIM = 2'd1,
    KIND_BAD   = 2'd2
  } kind_e;

  // Range, overlong and surrogate check of a finished multi-byte sequence.
  function automatic logic scalar_ok(input logic [2:0] len, input logic [CP_BITS-1:0] cp);
    logic ok;
    ok = 1'b0;
    case (len)
      3'd2: ok = (cp >= CP_MIN_2B);
      3'd3: ok = (cp >= CP_MIN_3B) && !((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
      3'd4: ok = (cp >= CP_MIN_4B) && (cp <= CP_MAX);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== sv/utf8_word_char_classifier.sv =====
// A result is registered and appears on the master side in the cycle after the byte that
// completes it is accepted. Throughput: one item per cycle while the master side takes
// results; the single result register is refilled in the cycle it drains. Backpressure on
// the master side stalls the slave side in the same cycle. Reset: rst_ni is asynchronous,
// active low; it clears sequence state, both counters and the result valid flag.
`default_nettype none

module utf8_word_char_classifier
  import u8wc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] byte_in
  input  wire logic                   s_axis_tuser,   // [0] stream_end
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [M_DATA_BITS-1:0] m_axis_tdata,   // [20:0] code_point, [36:21] line,
                                                      // [52:37] column, [55:53] zero
  output      logic [KIND_BITS-1:0]   m_axis_tuser    // [1:0] kind
);

  // Sequence state
  logic [1:0]             bytes_left_q, bytes_left_d;
  logic [2:0]             seq_len_q, seq_len_d;
  logic [CP_BITS-1:0]     accum_q, accum_d;
  logic                   cont_ok_q, cont_ok_d;

  // Position counters
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] column_q, column_d;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic [CP_BITS-1:0]     out_cp_q, out_cp_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [FIELD_BITS-1:0]  out_line_q, out_line_d;
  logic [FIELD_BITS-1:0]  out_col_q, out_col_d;

  logic                   accept;
  logic                   emit;
  kind_e                  emit_kind;
  logic [CP_BITS-1:0]     emit_cp;
  logic [CP_BITS-1:0]     shifted;
  logic                   cont_now;
  logic [7:0]             byte_in;
  logic                   stream_end;
  logic [31:0]            line_wide;
  logic [31:0]            column_wide;

  assign byte_in    = s_axis_tdata;
  assign stream_end = s_axis_tuser;

  // Take a new item whenever the result register is empty or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign shifted  = {accum_q[CP_BITS-7:0], byte_in[5:0]};
  assign cont_now = cont_ok_q && (byte_in[7:6] == 2'b10);

  // Sequence decode: one byte advances the gathering state or finishes a code point.
  always_comb begin
    bytes_left_d = bytes_left_q;
    seq_len_d    = seq_len_q;
    accum_d      = accum_q;
    cont_ok_d    = cont_ok_q;
    emit         = 1'b0;
    emit_kind    = KIND_BAD;
    emit_cp      = '0;

    if (accept) begin
      if (stream_end) begin
        // Flush an unfinished sequence as invalid; between sequences do nothing.
        if (bytes_left_q != 2'd0) begin
          emit         = 1'b1;
          bytes_left_d = 2'd0;
          seq_len_d    = 3'd0;
          accum_d      = '0;
          cont_ok_d    = 1'b1;
        end
      end else if (bytes_left_q != 2'd0) begin
        // Continuation: consume whatever it holds, remember if it was malformed.
        accum_d      = shifted;
        cont_ok_d    = cont_now;
        bytes_left_d = bytes_left_q - 2'd1;
        if (bytes_left_q == 2'd1) begin
          emit         = 1'b1;
          emit_cp      = shifted;
          emit_kind    = (cont_now && scalar_ok(seq_len_q, shifted)) ? KIND_WORD : KIND_BAD;
          seq_len_d    = 3'd0;
          accum_d      = '0;
          cont_ok_d    = 1'b1;
        end
      end else if (!byte_in[7]) begin
        emit    = 1'b1;
        emit_cp = CP_BITS'(byte_in);
        if (byte_in inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_HYPHEN, CH_APOS}) begin
          emit_kind = KIND_WORD;
        end else begin
          emit_kind = KIND_DELIM;
        end
      end else if (byte_in[7:5] == 3'b110) begin
        seq_len_d    = 3'd2;
        accum_d      = CP_BITS'(byte_in[4:0]);
        bytes_left_d = 2'd1;
        cont_ok_d    = 1'b1;
      end else if (byte_in[7:4] == 4'b1110) begin
        seq_len_d    = 3'd3;
        accum_d      = CP_BITS'(byte_in[3:0]);
        bytes_left_d = 2'd2;
        cont_ok_d    = 1'b1;
      end else if (byte_in[7:3] == 5'b11110) begin
        seq_len_d    = 3'd4;
        accum_d      = CP_BITS'(byte_in[2:0]);
        bytes_left_d = 2'd3;
        cont_ok_d    = 1'b1;
      end else begin
        // Stray continuation byte or lead byte F8-FF.
        emit = 1'b1;
      end
    end
  end

  // Position tracking: invalid results leave both counters alone.
  always_comb begin
    line_d   = line_q;
    column_d = column_q;
    if (emit && (emit_kind != KIND_BAD)) begin
      if (emit_cp == CP_NEWLINE) begin
        if (line_q != LINE_SAT) begin
          line_d = line_q + LINE_BITS'(1);
        end
        column_d = COLUMN_BITS'(1);
      end else if (column_q != COLUMN_SAT) begin
        column_d = column_q + COLUMN_BITS'(1);
      end
    end
  end

  assign line_wide   = 32'(line_d);
  assign column_wide = 32'(column_d);

  // Result register: load on an emitting accept, drop once the sink takes it.
  always_comb begin
    out_valid_d = accept ? emit : (out_valid_q && !m_axis_tready);
    out_cp_d    = out_cp_q;
    out_kind_d  = out_kind_q;
    out_line_d  = out_line_q;
    out_col_d   = out_col_q;
    if (accept && emit) begin
      out_cp_d   = (emit_kind == KIND_BAD) ? '0 : emit_cp;
      out_kind_d = emit_kind;
      out_line_d = line_wide[FIELD_BITS-1:0];
      out_col_d  = column_wide[FIELD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 2'd0;
      seq_len_q    <= 3'd0;
      accum_q      <= '0;
      cont_ok_q    <= 1'b1;
      line_q       <= '0;
      column_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      bytes_left_q <= bytes_left_d;
      seq_len_q    <= seq_len_d;
      accum_q      <= accum_d;
      cont_ok_q    <= cont_ok_d;
      line_q       <= line_d;
      column_q     <= column_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk_i) begin
    out_cp_q   <= out_cp_d;
    out_kind_q <= out_kind_d;
    out_line_q <= out_line_d;
    out_col_q  <= out_col_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_col_q, out_line_q, out_cp_q};
  assign m_axis_tuser  = out_kind_q;

endmodule

`default_nettype wire

// ===== sv/u8wc_checker.sv =====
`default_nettype none

module u8wc_checker
  import u8wc_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [7:0]             s_axis_tdata,
  input wire logic                   s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [M_DATA_BITS-1:0] m_axis_tdata,
  input wire logic [KIND_BITS-1:0]   m_axis_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Kind is never the unused code.
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_WORD) || (m_axis_tuser == KIND_DELIM) ||
                      (m_axis_tuser == KIND_BAD))
    else $error("bad kind code");

  // Invalid results carry a zero code point.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_BAD) |-> (m_axis_tdata[CP_BITS-1:0] == '0))
    else $error("invalid result with nonzero code point");

  // Delimiters are ASCII only.
  a_delim_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_DELIM) |-> (m_axis_tdata[CP_BITS-1:7] == '0))
    else $error("delimiter outside ASCII");

  // The input side is never blocked while the result register is empty.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

bind utf8_word_char_classifier u8wc_checker u_u8wc_checker (.*);

`default_nettype wire
